[src/hthr_pkg.sv]
// shared types and constants of the histogram threshold block
`default_nettype none
package hthr_pkg;
  localparam int BIN_W = 8;
  localparam int NUM_BINS = 256;
  localparam int OUT_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 21;
  localparam int LIMIT_DIV = 200;

  // division by 200 as a shift by 3 and a reciprocal of 25, exact below 2^22 after the shift
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_RECIP_W = 23;
  localparam int DIV_RECIP = 5368710;
  localparam int DIV_RECIP_SHIFT = 27;

  typedef logic [BIN_W-1:0] pixel_t;
  typedef logic [OUT_W-1:0] count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COMPUTE_THR = 2'd0;
  localparam cfg_idx_t CFG_DERIVE_LIM  = 2'd1;
  localparam cfg_idx_t CFG_FIXED_LIM   = 2'd2;
  localparam cfg_idx_t CFG_FIXED_THR   = 2'd3;

  localparam logic   RST_COMPUTE_THR = 1'b1;
  localparam logic   RST_DERIVE_LIM  = 1'b1;
  localparam count_t RST_FIXED_LIM   = 21'd5000;
  localparam pixel_t RST_FIXED_THR   = 8'd128;

  localparam pixel_t TOP_BIN = 8'd255;
  localparam pixel_t MIN_THR = 8'd1;
endpackage
`default_nettype wire

[src/hthr_if.sv]
// pixel request and result request channel interfaces
`default_nettype none
interface hthr_in_if;
  logic              valid;
  logic              ready;
  hthr_pkg::pixel_t  pixel;
  logic              frame_end;
  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink (input valid, input pixel, input frame_end, output ready);
endinterface

interface hthr_out_if;
  logic              valid;
  logic              ready;
  hthr_pkg::pixel_t  threshold;
  hthr_pkg::count_t  bright_count;
  hthr_pkg::count_t  limit_used;
  hthr_pkg::count_t  frame_pixels;
  modport source (output valid, output threshold, output bright_count, output limit_used,
                  output frame_pixels, input ready);
  modport sink (input valid, input threshold, input bright_count, input limit_used,
                input frame_pixels, output ready);
endinterface
`default_nettype wire

[src/hthr_ram.sv]
// generic single write port ram with registered read, read before write
`default_nettype none
module hthr_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/histogram_top_fraction_threshold.sv]
// histogram threshold top level: bin counting, limit division, scan and clear sweep
// pixels are taken one per cycle while idle; the bin read-modify-write forwards back-to-back hits
// after the last pixel: the divide state forms the limit, by reciprocal multiplication or from
// the fixed limit, then a sweep of the bin memory (scan and clear together), then the final state
// loads the result; in ready stays low from the last pixel until the result is loaded
// reset: a clearing sweep of the bin memory and the final state run with in ready low, no result
`default_nettype none
module histogram_top_fraction_threshold #(
  parameter int MAX_IMAGE_PIXELS = 1048576
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  hthr_in_if.sink                        in_s,
  hthr_out_if.source                     out_s,
  input  wire logic                      cfg_we,
  input  wire hthr_pkg::cfg_idx_t        cfg_idx,
  input  wire logic [hthr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CNT_W = $clog2(MAX_IMAGE_PIXELS + 1);
  localparam int LIM_W = (CNT_W > hthr_pkg::OUT_W) ? CNT_W : hthr_pkg::OUT_W;
  localparam int PROD_W = CNT_W - hthr_pkg::DIV_PRE_SHIFT + hthr_pkg::DIV_RECIP_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IMAGE_PIXELS);
  localparam logic [CNT_W:0]   MAX_SUM = (CNT_W + 1)'(MAX_IMAGE_PIXELS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // configuration
  logic             compute_thr_r;
  logic             derive_lim_r;
  hthr_pkg::count_t fixed_lim_r;
  hthr_pkg::pixel_t fixed_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compute_thr_r <= hthr_pkg::RST_COMPUTE_THR;
      derive_lim_r  <= hthr_pkg::RST_DERIVE_LIM;
      fixed_lim_r   <= hthr_pkg::RST_FIXED_LIM;
      fixed_thr_r   <= hthr_pkg::RST_FIXED_THR;
    end else if (cfg_we) begin
      case (cfg_idx)
        hthr_pkg::CFG_COMPUTE_THR: compute_thr_r <= cfg_wdata[0];
        hthr_pkg::CFG_DERIVE_LIM:  derive_lim_r  <= cfg_wdata[0];
        hthr_pkg::CFG_FIXED_LIM:   fixed_lim_r   <= cfg_wdata;
        hthr_pkg::CFG_FIXED_THR:   fixed_thr_r   <= cfg_wdata[hthr_pkg::BIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [1:0]                   state_r, state_nxt;
  logic                         in_acc;
  logic                         out_load;
  hthr_pkg::pixel_t             ptr_r;
  logic                         emit_r;

  // bin memory
  logic                         ram_we;
  hthr_pkg::pixel_t             ram_waddr, ram_raddr;
  logic [CNT_W-1:0]             ram_wdata, ram_rdata;

  hthr_ram #(
    .WIDTH(CNT_W),
    .DEPTH(hthr_pkg::NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_s.ready = (state_r == ST_IDLE);
  assign in_acc = in_s.valid && in_s.ready;

  // increment stage
  logic                         s1_v_r;
  hthr_pkg::pixel_t             s1_addr_r;
  logic                         s1_fwd_r;
  logic [CNT_W-1:0]             s1_wv_r;
  logic [CNT_W-1:0]             s1_cur, s1_inc;

  assign s1_cur = s1_fwd_r ? s1_wv_r : ram_rdata;
  assign s1_inc = (s1_cur >= MAX_CNT) ? MAX_CNT : s1_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= in_s.pixel;
    s1_fwd_r  <= s1_v_r && (in_s.pixel == s1_addr_r);
    s1_wv_r   <= s1_inc;
  end

  assign ram_raddr = (state_r == ST_SWEEP) ? ptr_r : in_s.pixel;
  assign ram_we    = s1_v_r || (state_r == ST_SWEEP);
  assign ram_waddr = s1_v_r ? s1_addr_r : ptr_r;
  assign ram_wdata = s1_v_r ? s1_inc : '0;

  // pixel count
  logic [CNT_W-1:0]             pix_r, pix_inc;
  logic [CNT_W-1:0]             tot_r;

  assign pix_inc = (pix_r >= MAX_CNT) ? MAX_CNT : pix_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (in_acc) begin
      pix_r <= in_s.frame_end ? '0 : pix_inc;
    end
  end

  // pixel count over the limit divisor: pre-shift, then reciprocal multiplication
  logic [PROD_W-1:0]            lim_prod;

  assign lim_prod = PROD_W'(tot_r[CNT_W-1:hthr_pkg::DIV_PRE_SHIFT])
                    * PROD_W'(hthr_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (in_acc && in_s.frame_end) begin
      tot_r <= pix_inc;
    end
  end

  // scan data stage
  logic                         d_v_r;
  hthr_pkg::pixel_t             d_bin_r;
  logic                         scan_on_r;
  logic [CNT_W-1:0]             sum_r;
  logic [CNT_W:0]               sum_add;
  logic [LIM_W-1:0]             lim_r;
  logic [LIM_W-1:0]             sum_ext, tot_ext;
  hthr_pkg::pixel_t             thr_r;
  logic                         div_done;

  assign sum_add  = {1'b0, sum_r} + {1'b0, ram_rdata};
  assign sum_ext  = LIM_W'(sum_r);
  assign tot_ext  = LIM_W'(tot_r);
  assign div_done = (state_r == ST_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r     <= 1'b0;
      scan_on_r <= 1'b0;
    end else begin
      d_v_r <= (state_r == ST_SWEEP);
      if (div_done) begin
        scan_on_r <= compute_thr_r;
      end else if (d_v_r && scan_on_r && (d_bin_r != '0) && !(sum_ext <= lim_r)) begin
        scan_on_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_bin_r <= ptr_r;
    if (div_done) begin
      sum_r <= '0;
      thr_r <= hthr_pkg::TOP_BIN;
      lim_r <= derive_lim_r ? LIM_W'(lim_prod[PROD_W-1:hthr_pkg::DIV_RECIP_SHIFT])
                            : LIM_W'(fixed_lim_r);
    end else if (d_v_r && scan_on_r && (d_bin_r != '0) && (sum_ext <= lim_r)) begin
      sum_r <= (sum_add > MAX_SUM) ? MAX_CNT : sum_add[CNT_W-1:0];
      thr_r <= d_bin_r - 1'b1;
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_s.frame_end) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (ptr_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!emit_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_s.valid || out_s.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      ptr_r   <= hthr_pkg::TOP_BIN;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_done) begin
        ptr_r  <= hthr_pkg::TOP_BIN;
        emit_r <= 1'b1;
      end else if (state_r == ST_SWEEP) begin
        ptr_r <= ptr_r - 1'b1;
      end
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (compute_thr_r) begin
        out_s.threshold    <= (thr_r == '0) ? hthr_pkg::MIN_THR : thr_r;
        out_s.bright_count <= sum_ext[hthr_pkg::OUT_W-1:0];
      end else begin
        out_s.threshold    <= fixed_thr_r;
        out_s.bright_count <= '0;
      end
      out_s.limit_used   <= lim_r[hthr_pkg::OUT_W-1:0];
      out_s.frame_pixels <= tot_ext[hthr_pkg::OUT_W-1:0];
    end
  end

  assign out_s.valid = out_valid_r;
endmodule
`default_nettype wire

[src/hthr_chk.sv]
// port level checks of the histogram threshold block and their bind
`default_nettype none
module hthr_chk (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_frame_end,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire hthr_pkg::count_t out_bright_count,
  input wire hthr_pkg::count_t out_frame_pixels
);
  // result request holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before taken");

  // frame end stalls the pixel side while the sweep runs
  a_stall_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end |=> !in_ready)
    else $error("pixel taken right after frame end");

  // scan sum never exceeds the frame pixel count
  a_bright_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bright_count <= out_frame_pixels)
    else $error("bright count above frame pixels");

  // clearing sweep after reset holds the pixel side off
  a_reset_sweep: assert property (@(posedge clk)
    rst_n && $past(rst_n == 1'b0) |-> !in_ready && !out_valid)
    else $error("block active right after reset");
endmodule

bind histogram_top_fraction_threshold hthr_chk u_hthr_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .in_frame_end     (in_s.frame_end),
  .out_valid        (out_s.valid),
  .out_ready        (out_s.ready),
  .out_bright_count (out_s.bright_count),
  .out_frame_pixels (out_s.frame_pixels)
);
`default_nettype wire

[test/tb.sv]
// testbench for the histogram threshold block: directed and random frames vs. a built-in scan model
`timescale 1ns / 100ps
module tb;
  localparam int unsigned MAX_PIX = 1048576;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES = 12;

  typedef struct {
    hthr_pkg::pixel_t px;
    logic             last;
  } pixel_req_t;

  typedef struct {
    hthr_pkg::pixel_t threshold;
    hthr_pkg::count_t bright_count;
    hthr_pkg::count_t limit_used;
    hthr_pkg::count_t frame_pixels;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  hthr_pkg::cfg_idx_t cfg_idx;
  logic [hthr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hthr_in_if in_if ();
  hthr_out_if out_if ();

  histogram_top_fraction_threshold u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_if),
    .out_s    (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  int unsigned      hist_bins [hthr_pkg::NUM_BINS];
  int unsigned      hist_total;
  logic             compute_thr_r = hthr_pkg::RST_COMPUTE_THR;
  logic             derive_lim_r = hthr_pkg::RST_DERIVE_LIM;
  hthr_pkg::count_t fixed_lim_r = hthr_pkg::RST_FIXED_LIM;
  hthr_pkg::pixel_t fixed_thr_r = hthr_pkg::RST_FIXED_THR;

  pixel_req_t    pending_pixels [$];
  frame_result_t expected_frames [$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  frames_checked = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;

  initial begin
    foreach (hist_bins[i]) hist_bins[i] = 0;
    hist_total = 0;
  end

  task automatic predict_pixel(input hthr_pkg::pixel_t px, input logic last);
    frame_result_t r;
    longint unsigned sum;
    longint unsigned lim;
    int bin;
    if (hist_bins[px] < MAX_PIX) hist_bins[px]++;
    if (hist_total < MAX_PIX) hist_total++;
    if (last) begin
      lim = derive_lim_r ? hist_total / hthr_pkg::LIMIT_DIV : fixed_lim_r;
      sum = 0;
      if (compute_thr_r) begin
        bin = hthr_pkg::NUM_BINS - 1;
        while (bin > 0 && sum <= lim) begin
          sum += hist_bins[bin];
          if (sum > MAX_PIX) sum = MAX_PIX;
          bin--;
        end
        r.threshold = (bin == 0) ? hthr_pkg::MIN_THR : hthr_pkg::pixel_t'(bin);
      end else begin
        r.threshold = fixed_thr_r;
      end
      r.bright_count = hthr_pkg::count_t'(sum);
      r.limit_used = hthr_pkg::count_t'(lim);
      r.frame_pixels = hthr_pkg::count_t'(hist_total);
      expected_frames.insert(expected_frames.size(), r);
      foreach (hist_bins[i]) hist_bins[i] = 0;
      hist_total = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input frame_result_t e,
                                 input frame_result_t a);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected thr %0d bright %0d limit %0d pixels %0d,",
               what, e.threshold, e.bright_count, e.limit_used, e.frame_pixels,
               " got thr %0d bright %0d limit %0d pixels %0d",
               a.threshold, a.bright_count, a.limit_used, a.frame_pixels);
  endtask

  // pixel request driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : pixel_driver
    pixel_req_t req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      if (in_if.valid) begin
        predict_pixel(in_if.pixel, in_if.frame_end);
        pixels_sent++;
      end
      if (gap_left != 0 && !quiet) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_pixels.size() != 0) begin
        req = pending_pixels.pop_front();
        in_if.valid <= 1'b1;
        in_if.pixel <= req.px;
        in_if.frame_end <= req.last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = $urandom_range(1, 8);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result request monitor
  int stall_left = 0;
  always @(posedge clk) begin : result_monitor
    frame_result_t e;
    frame_result_t a;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        a.threshold = out_if.threshold;
        a.bright_count = out_if.bright_count;
        a.limit_used = out_if.limit_used;
        a.frame_pixels = out_if.frame_pixels;
        frames_checked++;
        if (expected_frames.size() == 0) begin
          e = '{default: '0};
          report_mismatch("no result expected", e, a);
        end else begin
          e = expected_frames.pop_front();
          if (e != a) report_mismatch("wrong field", e, a);
        end
      end
      if (stall_left != 0 && !quiet) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 24);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_px(input hthr_pkg::pixel_t px, input logic last);
    pixel_req_t req;
    req.px = px;
    req.last = last;
    pending_pixels.insert(pending_pixels.size(), req);
  endtask

  task automatic queue_frame(input int len, input int style);
    int centre;
    int spread;
    int v;
    centre = $urandom_range(0, 255);
    spread = $urandom_range(0, 24);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = $urandom_range(0, 255);
        1: v = centre + $urandom_range(0, 2 * spread) - spread;
        2: v = $urandom_range(224, 255);
        default: v = $urandom_range(0, 3);
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      push_px(hthr_pkg::pixel_t'(v), i == len - 1);
    end
  endtask

  task automatic write_reg(input hthr_pkg::cfg_idx_t idx,
                           input logic [hthr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      hthr_pkg::CFG_COMPUTE_THR: compute_thr_r = data[0];
      hthr_pkg::CFG_DERIVE_LIM:  derive_lim_r = data[0];
      hthr_pkg::CFG_FIXED_LIM:   fixed_lim_r = data;
      hthr_pkg::CFG_FIXED_THR:   fixed_thr_r = data[hthr_pkg::BIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic comp, input logic der, input hthr_pkg::count_t lim,
                               input hthr_pkg::pixel_t thr);
    logic [hthr_pkg::CFG_DATA_W-1:0] junk;
    junk = hthr_pkg::CFG_DATA_W'($urandom);
    write_reg(hthr_pkg::CFG_COMPUTE_THR, {junk[hthr_pkg::CFG_DATA_W-1:1], comp});
    junk = hthr_pkg::CFG_DATA_W'($urandom);
    write_reg(hthr_pkg::CFG_DERIVE_LIM, {junk[hthr_pkg::CFG_DATA_W-1:1], der});
    write_reg(hthr_pkg::CFG_FIXED_LIM, lim);
    junk = hthr_pkg::CFG_DATA_W'($urandom);
    write_reg(hthr_pkg::CFG_FIXED_THR,
              {junk[hthr_pkg::CFG_DATA_W-1:hthr_pkg::BIN_W], thr});
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_if.valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic comp;
    logic der;
    hthr_pkg::count_t lim;
    hthr_pkg::pixel_t thr;
    int phase_items;
    int len;
    in_if.valid = 1'b0;
    in_if.pixel = '0;
    in_if.frame_end = 1'b0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = hthr_pkg::CFG_COMPUTE_THR;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    do @(posedge clk); while (!in_if.ready);

    // directed frames at reset settings
    push_px(8'd0, 1'b1);
    push_px(8'd255, 1'b1);
    push_px(8'd1, 1'b0);
    push_px(8'd1, 1'b1);
    repeat (3) push_px(8'd7, 1'b0);
    push_px(8'd7, 1'b1);
    push_px(8'hAA, 1'b0);
    push_px(8'h55, 1'b0);
    push_px(8'h80, 1'b0);
    push_px(8'h7F, 1'b0);
    push_px(8'h01, 1'b0);
    push_px(8'hFE, 1'b1);
    push_px(8'd254, 1'b0);
    push_px(8'd255, 1'b0);
    push_px(8'd0, 1'b0);
    push_px(8'd255, 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin comp = 1'b1; der = 1'b0; lim = '0; thr = 8'd77; end
        1: begin comp = 1'b1; der = 1'b0; lim = '1; thr = 8'd3; end
        2: begin comp = 1'b0; der = 1'b1; lim = 21'd12; thr = 8'd0; end
        3: begin comp = 1'b0; der = 1'b0; lim = 21'd1; thr = 8'd255; end
        4: begin
          comp = 1'b1; der = 1'b0; lim = hthr_pkg::count_t'(MAX_PIX); thr = 8'd128;
        end
        5: begin comp = 1'b1; der = 1'b1; lim = 21'd5; thr = 8'd200; end
        default: begin
          comp = ($urandom_range(0, 4) != 0);
          der = 1'($urandom_range(0, 1));
          lim = ($urandom_range(0, 3) == 0) ? hthr_pkg::count_t'($urandom)
                                             : hthr_pkg::count_t'($urandom_range(0, 40));
          thr = hthr_pkg::pixel_t'($urandom_range(0, 255));
        end
      endcase
      apply_setting(comp, der, lim, thr);
      quiet = (p % 4 == 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (der && $urandom_range(0, 29) == 0) len = $urandom_range(200, 260);
        else if ($urandom_range(0, 5) == 0) len = $urandom_range(1, 3);
        else len = $urandom_range(4, 30);
        queue_frame(len, $urandom_range(0, 3));
        phase_items += len;
      end
      wait_drained();
    end

    $display("checked %0d frame results from %0d pixels over %0d register settings",
             frames_checked, pixels_sent, settings_used + 1);
    $display("covered fixed and derived limits, fixed threshold mode and idle/stall patterns");
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_frames.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
